// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file sdfp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent, reset included.
`define ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/sdfp_pkg.sv =====
package sdfp_pkg;

   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [2:0] PHASE_START   = 3'd0;
   localparam logic [2:0] PHASE_SPACE   = 3'd5;
   localparam logic [2:0] PHASE_PAYLOAD = 3'd6;
   localparam logic [2:0] PHASE_SKIP    = 3'd7;

   localparam logic [2:0] SENTINEL_LEN = 3'd6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // One front decision: replay held sentinel bytes, then a payload byte or an end mark.
   typedef struct packed {
      logic [2:0] held;
      logic       is_end;
      logic [7:0] data;
   } cmd_type;

   function automatic logic [7:0] data_tag_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h64;
         3'd1:    c = 8'h61;
         3'd2:    c = 8'h74;
         3'd3:    c = 8'h61;
         3'd4:    c = 8'h3a;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] done_tag_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h5b;
         3'd1:    c = 8'h44;
         3'd2:    c = 8'h4f;
         3'd3:    c = 8'h4e;
         3'd4:    c = 8'h45;
         3'd5:    c = 8'h5d;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== src/sdfp_front.sv =====
module sdfp_front import sdfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   output logic       cmd_valid,
   output cmd_type    cmd
);

   logic [2:0] phase_ff, phase_in;
   logic       lwn_ff, lwn_in;
   logic       dropped_ff, dropped_in;
   logic [2:0] count_ff, count_in;
   logic       broken_ff, broken_in;
   logic       seen_ff, seen_in;
   logic       is_payload;

   always_comb begin
      phase_in   = phase_ff;
      lwn_in     = lwn_ff;
      dropped_in = dropped_ff;
      count_in   = count_ff;
      broken_in  = broken_ff;
      seen_in    = seen_ff;
      cmd_valid  = 1'b0;
      cmd.held   = 3'd0;
      cmd.is_end = 1'b0;
      cmd.data   = in_byte;
      is_payload = 1'b0;

      if (in_byte == CHAR_LF) begin
         if (lwn_ff) begin
            if (seen_ff && (broken_ff || count_ff != SENTINEL_LEN)) begin
               cmd_valid  = 1'b1;
               cmd.held   = broken_ff ? 3'd0 : count_ff;
               cmd.is_end = 1'b1;
               cmd.data   = 8'h00;
            end
            phase_in   = PHASE_START;
            lwn_in     = 1'b0;
            dropped_in = 1'b0;
            count_in   = 3'd0;
            broken_in  = 1'b0;
            seen_in    = 1'b0;
         end else begin
            lwn_in   = 1'b1;
            phase_in = PHASE_START;
         end
      end else begin
         lwn_in = 1'b0;
         if (!dropped_ff) begin
            if (in_byte == CHAR_NUL) begin
               dropped_in = 1'b1;
            end else if (phase_ff < PHASE_SPACE) begin
               if (in_byte == data_tag_char(phase_ff)) begin
                  phase_in = phase_ff + 3'd1;
               end else begin
                  phase_in = PHASE_SKIP;
               end
            end else if (phase_ff == PHASE_SPACE) begin
               phase_in   = PHASE_PAYLOAD;
               is_payload = (in_byte != CHAR_SPACE);
            end else if (phase_ff == PHASE_PAYLOAD) begin
               is_payload = 1'b1;
            end
         end
      end

      if (is_payload) begin
         seen_in = 1'b1;
         if (broken_ff) begin
            cmd_valid = 1'b1;
         end else if (count_ff < SENTINEL_LEN && in_byte == done_tag_char(count_ff)) begin
            count_in = count_ff + 3'd1;
         end else begin
            broken_in = 1'b1;
            cmd_valid = 1'b1;
            cmd.held  = count_ff;
            count_in  = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_START;
         lwn_ff     <= 1'b0;
         dropped_ff <= 1'b0;
         count_ff   <= 3'd0;
         broken_ff  <= 1'b0;
         seen_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         lwn_ff     <= lwn_in;
         dropped_ff <= dropped_in;
         count_ff   <= count_in;
         broken_ff  <= broken_in;
         seen_ff    <= seen_in;
      end
   end

endmodule

// ===== src/sdfp_queue.sv =====
module sdfp_queue import sdfp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/sdfp_back.sv =====
module sdfp_back import sdfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head,
   output logic       head_done,
   input  logic       pop,
   output logic [7:0] out_byte,
   output logic       byte_valid,
   output logic       message_end,
   output logic       last
);

   logic [2:0] idx_ff, idx_in;
   logic       in_tail;
   logic       step;

   assign in_tail   = (idx_ff == head.held);
   assign step      = pop && head_valid;
   assign head_done = step && in_tail;

   always_comb begin
      if (in_tail) begin
         out_byte    = head.is_end ? 8'h00 : head.data;
         byte_valid  = !head.is_end;
         message_end = head.is_end;
         last        = 1'b1;
      end else begin
         out_byte    = done_tag_char(idx_ff);
         byte_valid  = 1'b1;
         message_end = 1'b0;
         last        = 1'b0;
      end
      idx_in = idx_ff;
      if (step) begin
         idx_in = in_tail ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== src/sse_data_frame_parser.sv =====
// Ordering: a byte that causes results queues one registered command, shown after any older commands.
// Throughput: one input byte per cycle; results leave one per cycle while rsp_pop is high, and a byte causing
// up to seven results (held sentinel replay) stalls input only once the four-entry
// command queue between parser and expander is full.
// Reset: synchronous, active high; clears parser state and empties the queue.
module sse_data_frame_parser import sdfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_message_end,
   output logic       rsp_last
);

   logic    accept;
   logic    cmd_valid;
   cmd_type cmd;
   cmd_type head;
   logic    head_done;

   assign accept = req_push && !req_full;

   sdfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   sdfp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept && cmd_valid),
      .push_cmd (cmd),
      .full     (req_full),
      .pop      (head_done),
      .empty    (rsp_empty),
      .head     (head)
   );

   sdfp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (!rsp_empty),
      .head        (head),
      .head_done   (head_done),
      .pop         (rsp_pop),
      .out_byte    (rsp_out_byte),
      .byte_valid  (rsp_byte_valid),
      .message_end (rsp_message_end),
      .last        (rsp_last)
   );

endmodule

// ===== src/sdfp_checker.sv =====
`include "assert_macros.svh"

module sdfp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_message_end,
   input logic       rsp_last
);

   logic shown;

   assign shown = !rsp_empty;

   `ASSERT_IMPLIES(a_one_kind, clock, reset, shown, rsp_byte_valid != rsp_message_end)
   `ASSERT_IMPLIES(a_end_is_last, clock, reset, shown && rsp_message_end, rsp_last)
   `ASSERT_IMPLIES(a_end_zero_byte, clock, reset, shown && !rsp_byte_valid, rsp_out_byte == 8'h00)
   `ASSERT_NEXT(a_reset_empty, clock, reset, rsp_empty && !req_full)
   `ASSERT_IMPLIES(a_held_then_more, clock, reset, $past(shown && rsp_pop && !rsp_last && !reset), shown)

endmodule

bind sse_data_frame_parser sdfp_checker u_sdfp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_byte_valid  (rsp_byte_valid),
   .rsp_message_end (rsp_message_end),
   .rsp_last        (rsp_last)
);
